FILE: design/cdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg: shared constants and types for the common divisor counter
// Widths, table sizes, saturation limits and the controller state type.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_PRIMES  = 9;

	localparam int IDX_W     = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
	localparam int PCNT_W    = $clog2(MAX_PRIMES + 1);
	localparam int EXP_W     = 5;
	localparam int CNT_W     = 11;
	localparam int STEP_W    = $clog2(VALUE_WIDTH + 1);
	localparam int PROD_W    = CNT_W + EXP_W + 1;

	localparam logic [EXP_W-1:0]       EXP_MAX      = 5'd31;
	localparam logic [CNT_W-1:0]       COUNT_MAX    = 11'd2047;
	localparam logic [VALUE_WIDTH-1:0] TRIAL_FIRST  = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] TRIAL_SECOND = VALUE_WIDTH'(3);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FSTART,
		ST_FWAIT,
		ST_ESTART,
		ST_EWAIT,
		ST_FLEFT,
		ST_QINIT,
		ST_QSEL,
		ST_QSTART,
		ST_QWAIT,
		ST_QMUL,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: design/cdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_div: bit-serial restoring divider
// Produces one quotient bit per cycle; a start while busy is ignored.
// ----------------------------------------------------------------------------
module cdc_div
	import cdc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [VALUE_WIDTH-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      quotient,
	output logic [VALUE_WIDTH-1:0]      remainder
);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [STEP_W-1:0]      step_q;
	logic                   run_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(VALUE_WIDTH);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			// The remainder never reaches the divisor, so the low bits of
			// the difference hold it whenever the trial fits.
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign busy      = run_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: design/common_divisor_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// common_divisor_counter: count of common divisors by trial division
// Factors the reference once after each write, then counts per query.
// ----------------------------------------------------------------------------
//  channel    signals                               direction
//  cfg        cfg_valid cfg_ready reference_value   in
//  query      query_valid query_ready query_value   in
//  count      count_valid count_ready common_count  out
//
// Every division runs through one bit-serial divider. A query costs about
// (sum of capped exponents + stored primes) divisions. The first query
// after a reference write first factors the reference, trying 2 and then
// each odd trial divisor up to the square root of what is left of it.
// Reset leaves the table invalid, so the first query factors the reset value.
// A result waiting on count_ready holds back the next query only at the end.
// ----------------------------------------------------------------------------
module common_divisor_counter
	import cdc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [VALUE_WIDTH-1:0] reference_value,
	input  wire logic                   query_valid,
	output logic                        query_ready,
	input  wire logic [VALUE_WIDTH-1:0] query_value,
	output logic                        count_valid,
	input  wire logic                   count_ready,
	output logic [CNT_W-1:0]            common_count
);

	state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] ref_q;
	logic                   tvalid_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [EXP_W-1:0]       e_q;
	logic [PCNT_W-1:0]      pcnt_q;
	logic [VALUE_WIDTH-1:0] prime_q [MAX_PRIMES];
	logic [EXP_W-1:0]       exp_q   [MAX_PRIMES];
	logic [VALUE_WIDTH-1:0] qv_q;
	logic [PCNT_W-1:0]      k_q;
	logic [EXP_W-1:0]       c_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [CNT_W-1:0]       out_q;

	logic                   div_start;
	logic                   div_busy;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_a;
	logic [VALUE_WIDTH-1:0] div_b;
	logic [VALUE_WIDTH-1:0] div_quo;
	logic [VALUE_WIDTH-1:0] div_rem;

	logic [IDX_W-1:0]       k_idx;
	logic [VALUE_WIDTH-1:0] cur_prime;
	logic [EXP_W-1:0]       cur_exp;
	logic [PROD_W-1:0]      prod;
	logic                   store_en;
	logic [VALUE_WIDTH-1:0] store_p;
	logic [EXP_W-1:0]       store_e;
	logic [VALUE_WIDTH-1:0] d_next;
	logic                   out_load;

	assign k_idx     = k_q[IDX_W-1:0];
	assign cur_prime = prime_q[k_idx];
	assign cur_exp   = exp_q[k_idx];
	assign prod      = PROD_W'(cnt_q) * PROD_W'({1'b0, c_q} + 6'd1);
	assign d_next    = (d_q == TRIAL_FIRST) ? TRIAL_SECOND : d_q + VALUE_WIDTH'(2);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || count_ready);

	cdc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (query_valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (tvalid_q) state_d = ST_QINIT;
				else if (ref_q == '0) state_d = ST_QINIT;
				else state_d = ST_FSTART;
			end
			ST_FSTART: state_d = ST_FWAIT;
			ST_FWAIT: begin
				if (div_done) begin
					if (d_q != TRIAL_FIRST && d_q > div_quo) state_d = ST_FLEFT;
					else if (div_rem == '0) state_d = ST_ESTART;
					else state_d = ST_FSTART;
				end
			end
			ST_ESTART: state_d = ST_EWAIT;
			ST_EWAIT: begin
				if (div_done) begin
					state_d = (div_rem == '0) ? ST_ESTART : ST_FSTART;
				end
			end
			ST_FLEFT:  state_d = ST_QINIT;
			ST_QINIT:  state_d = ST_QSEL;
			ST_QSEL: begin
				if (k_q >= pcnt_q) state_d = ST_OUT;
				else if (qv_q == '0) state_d = ST_QMUL;
				else if (c_q < cur_exp) state_d = ST_QSTART;
				else state_d = ST_QMUL;
			end
			ST_QSTART: state_d = ST_QWAIT;
			ST_QWAIT: begin
				if (div_done) state_d = (div_rem == '0) ? ST_QSEL : ST_QMUL;
			end
			ST_QMUL:   state_d = ST_QSEL;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs and control strobes.
	always_comb begin
		query_ready = (state_q == ST_IDLE);
		cfg_ready   = (state_q == ST_IDLE);
		div_start   = (state_q inside {ST_FSTART, ST_ESTART, ST_QSTART});
		div_a       = (state_q == ST_QSTART) ? qv_q : n_q;
		div_b       = (state_q == ST_QSTART) ? cur_prime : d_q;
		store_en    = 1'b0;
		store_p     = d_q;
		store_e     = e_q;
		case (state_q)
			ST_EWAIT: store_en = div_done && (div_rem != '0);
			ST_FLEFT: begin
				store_en = (n_q > VALUE_WIDTH'(1));
				store_p  = n_q;
				store_e  = EXP_W'(1);
			end
			default: store_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_q       <= VALUE_WIDTH'(1);
			tvalid_q    <= 1'b0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_PRIMES; i++) exp_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				ref_q    <= reference_value;
				tvalid_q <= 1'b0;
			end
			if (state_q == ST_CHECK && !tvalid_q) begin
				pcnt_q   <= '0;
				tvalid_q <= 1'b1;
			end
			if (store_en && pcnt_q < PCNT_W'(MAX_PRIMES)) begin
				exp_q[pcnt_q[IDX_W-1:0]] <= store_e;
				pcnt_q <= pcnt_q + 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (count_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_en && pcnt_q < PCNT_W'(MAX_PRIMES)) prime_q[pcnt_q[IDX_W-1:0]] <= store_p;
		if (out_load) out_q <= cnt_q;
		case (state_q)
			ST_IDLE: if (query_valid) qv_q <= query_value;
			ST_CHECK: begin
				n_q <= ref_q;
				d_q <= TRIAL_FIRST;
			end
			ST_FWAIT: begin
				if (div_done) begin
					if (!(d_q != TRIAL_FIRST && d_q > div_quo)) begin
						if (div_rem == '0) begin
							n_q <= div_quo;
							e_q <= EXP_W'(1);
						end else begin
							d_q <= d_next;
						end
					end
				end
			end
			ST_EWAIT: begin
				if (div_done) begin
					if (div_rem == '0) begin
						n_q <= div_quo;
						if (e_q < EXP_MAX) e_q <= e_q + 1'b1;
					end else begin
						d_q <= d_next;
					end
				end
			end
			ST_QINIT: begin
				k_q   <= '0;
				c_q   <= '0;
				cnt_q <= CNT_W'(1);
			end
			ST_QSEL: begin
				// A query of zero is a multiple of every stored prime power.
				if (k_q < pcnt_q && qv_q == '0) c_q <= cur_exp;
			end
			ST_QWAIT: begin
				if (div_done && div_rem == '0) begin
					qv_q <= div_quo;
					c_q  <= c_q + 1'b1;
				end
			end
			ST_QMUL: begin
				cnt_q <= (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[CNT_W-1:0];
				k_q   <= k_q + 1'b1;
				c_q   <= '0;
			end
			default: ;
		endcase
	end

	assign count_valid  = out_valid_q;
	assign common_count = out_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCNT_W'(MAX_PRIMES))
		else $error("prime count beyond table size");

	a_query_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QSTART) |-> (k_q < pcnt_q && qv_q != '0))
		else $error("query division on an unused table entry");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_FWAIT || state_q == ST_EWAIT || state_q == ST_QWAIT))
		else $error("divider result arrived outside a wait state");

endmodule
`default_nettype wire

FILE: bench/common_divisor_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// common_divisor_counter_test: self-checking bench for the divisor counter
// Sets a series of reference numbers and sends queries built mostly from the
// primes of the current reference. A local factoring predictor supplies the
// expected count of common divisors for each accepted query.
// ----------------------------------------------------------------------------
module common_divisor_counter_test;
	import cdc_pkg::*;

	class divisor_scoreboard;
		logic [VALUE_WIDTH-1:0] primes [MAX_PRIMES];
		int                     exps [MAX_PRIMES];
		int                     nprimes;
		logic [CNT_W-1:0]       expected_counts [$];

		function new();
			nprimes = 0;
		endfunction

		function void add_prime(ref longint unsigned n, input longint unsigned p);
			int e;
			e = 0;
			while (n % p == 0) begin
				n = n / p;
				if (e < 31) e++;
			end
			if (nprimes < MAX_PRIMES) begin
				primes[nprimes] = p[VALUE_WIDTH-1:0];
				exps[nprimes] = e;
				nprimes++;
			end
		endfunction

		function void set_reference(logic [VALUE_WIDTH-1:0] r);
			longint unsigned n;
			longint unsigned d;
			n = r;
			nprimes = 0;
			if (n == 0) return;
			if (n % 2 == 0) add_prime(n, 2);
			for (d = 3; d <= n / d; d += 2)
				if (n % d == 0) add_prime(n, d);
			if (n > 1) add_prime(n, n);
		endfunction

		function void note_query(logic [VALUE_WIDTH-1:0] q);
			longint unsigned rest;
			longint unsigned total;
			int c;
			rest = q;
			total = 1;
			for (int k = 0; k < nprimes; k++) begin
				c = 0;
				while (c < exps[k] && rest % primes[k] == 0) begin
					rest = rest / primes[k];
					c++;
				end
				total = total * (c + 1);
				if (total > 2047) total = 2047;
			end
			expected_counts = {expected_counts, total[CNT_W-1:0]};
		endfunction

		// Returns 0 on a match, 1 on a wrong count, 2 when nothing was expected.
		function int check_count(logic [CNT_W-1:0] got, output logic [CNT_W-1:0] want);
			want = '0;
			if (expected_counts.size() == 0) return 2;
			want = expected_counts.pop_front();
			return (got === want) ? 0 : 1;
		endfunction

		function int pending();
			return expected_counts.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [VALUE_WIDTH-1:0] reference_value = '0;
	logic                   query_valid = 1'b0;
	logic                   query_ready;
	logic [VALUE_WIDTH-1:0] query_value = '0;
	logic                   count_valid;
	logic                   count_ready = 1'b0;
	logic [CNT_W-1:0]       common_count;

	divisor_scoreboard sb = new();
	int errors = 0;
	int burst_left = 0;
	int stall_mode = 0;

	common_divisor_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.reference_value(reference_value),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query_value(query_value),
		.count_valid(count_valid),
		.count_ready(count_ready),
		.common_count(common_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

	task report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// The receiver switches between always ready, light stalls and long stalls.
	always @(posedge clk) begin
		logic [CNT_W-1:0] want;
		int verdict;
		if (arst_n && count_valid && count_ready) begin
			verdict = sb.check_count(common_count, want);
			if (verdict == 2)
				report($sformatf("count %0d with no query waiting", common_count));
			else if (verdict == 1)
				report($sformatf("count %0d, expected %0d", common_count, want));
		end
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: count_ready <= 1'b1;
			1: count_ready <= ($urandom_range(0, 3) != 0);
			default: count_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	task send_query(logic [VALUE_WIDTH-1:0] q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				query_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		query_valid <= 1'b1;
		query_value <= q;
		do @(posedge clk); while (!query_ready);
		sb.note_query(q);
		burst_left--;
	endtask

	task wait_idle();
		query_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task write_reference(logic [VALUE_WIDTH-1:0] r);
		cfg_valid <= 1'b1;
		reference_value <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reference(r);
	endtask

	// Mostly products of the stored primes, so the capped counts get exercised.
	function logic [VALUE_WIDTH-1:0] pick_query();
		longint unsigned q;
		longint unsigned lim;
		int reps;
		lim = 64'hFFFF_FFFF;
		if ($urandom_range(0, 3) == 0 || sb.nprimes == 0) begin
			q = $urandom();
			if (q == 0) q = 1;
			return q[VALUE_WIDTH-1:0];
		end
		q = 1;
		for (int k = 0; k < sb.nprimes; k++) begin
			reps = $urandom_range(0, sb.exps[k] + 1);
			for (int j = 0; j < reps; j++)
				if (q * sb.primes[k] <= lim) q = q * sb.primes[k];
		end
		reps = $urandom_range(1, 15);
		if (q * reps <= lim) q = q * reps;
		return q[VALUE_WIDTH-1:0];
	endfunction

	function logic [VALUE_WIDTH-1:0] smooth_reference();
		longint unsigned r;
		int small_primes [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};
		int p;
		r = 1;
		repeat ($urandom_range(1, 20)) begin
			p = small_primes[$urandom_range(0, 11)];
			if (r * p <= 64'hFFFF_FFFF) r = r * p;
		end
		return r[VALUE_WIDTH-1:0];
	endfunction

	initial begin
		logic [VALUE_WIDTH-1:0] refs [8];
		refs = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd223092870,
			32'd720720, 32'd4293984256, 32'd0, 32'd0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset value of the reference is one: every query counts one divisor.
		send_query(32'hFFFF_FFFF);
		send_query(32'd1);
		wait_idle();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph >= 6) refs[ph] = smooth_reference();
			write_reference(refs[ph]);
			send_query(32'd1);
			send_query(32'hFFFF_FFFF);
			send_query(refs[ph] == 0 ? 32'd1 : refs[ph]);
			repeat (47) send_query(pick_query());
			wait_idle();
		end
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
